// ----- rtl/twrtc_pkg.sv -----
// Shared types, codes and pin helpers for the three-wire RTC serial master.
// No dependencies; the rtl/ top level and the testbench use this package, by scope.
`default_nettype none

package twrtc_pkg;

  // Request codes carried in the action field
  localparam logic [2:0] ACT_TICK  = 3'd0;
  localparam logic [2:0] ACT_OPEN  = 3'd1;
  localparam logic [2:0] ACT_PARAM = 3'd2;
  localparam logic [2:0] ACT_READ  = 3'd3;
  localparam logic [2:0] ACT_CLOSE = 3'd4;

  localparam logic [15:0] HALF_PERIOD_RESET = 16'd48;
  localparam logic [4:0]  HALF_BITS_PER_BYTE = 5'd16;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_OPEN,
    MODE_CMD,
    MODE_PARAM,
    MODE_READ,
    MODE_CLOSE
  } mode_t;

  typedef struct packed {
    logic cs;
    logic sck;
    logic drv;
    logic lvl;
  } pins_t;

  localparam pins_t PINS_RESET = '{cs: 1'b0, sck: 1'b1, drv: 1'b0, lvl: 1'b0};

  // Pin levels during one half period of a data byte
  function automatic pins_t bit_pins(mode_t mode, logic [4:0] half_bit, logic [7:0] shift);
    pins_t p;
    p     = '{cs: 1'b1, sck: half_bit[0], drv: 1'b0, lvl: 1'b0};
    if (mode == MODE_CMD) begin
      p.drv = 1'b1;
      p.lvl = shift[7];
    end else if (mode == MODE_PARAM) begin
      p.drv = 1'b1;
      p.lvl = shift[0];
    end
    return p;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/twrtc_req_if.sv -----
// Request channel of the three-wire RTC serial master: valid/ready plus payload.
// Depends on nothing.
`default_nettype none

interface twrtc_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [7:0] data_byte;
  logic       sio_in;

  modport source (output valid, output action, output data_byte, output sio_in, input ready);
  modport sink   (input valid, input action, input data_byte, input sio_in, output ready);
endinterface

`default_nettype wire

// ----- rtl/twrtc_rsp_if.sv -----
// Result channel of the three-wire RTC serial master: valid/ready plus pin state.
// Depends on nothing.
`default_nettype none

interface twrtc_rsp_if;
  logic       valid;
  logic       ready;
  logic       cs_level;
  logic       sck_level;
  logic       sio_drive;
  logic       sio_level;
  logic [7:0] read_data;
  logic       read_valid;
  logic       busy_res;
  logic       rejected;

  modport source (output valid, output cs_level, output sck_level, output sio_drive,
                  output sio_level, output read_data, output read_valid, output busy_res,
                  output rejected, input ready);
  modport sink   (input valid, input cs_level, input sck_level, input sio_drive,
                  input sio_level, input read_data, input read_valid, input busy_res,
                  input rejected, output ready);
endinterface

`default_nettype wire

// ----- rtl/three_wire_rtc_serial_master.sv -----
// Top level of the three-wire RTC serial master (CS, SCK, bidirectional SIO).
// Depends on twrtc_pkg, twrtc_req_if and twrtc_rsp_if.
//
// Usage:
//   req : one request per handshake: a timer tick (action 0) or a command
//         (1 open + command byte, 2 parameter byte, 3 read byte, 4 close).
//         sio_in carries the sampled data-line level with each request.
//   rsp : exactly one result per request, in order: pin levels to drive,
//         read byte with its strobe, busy flag and a reject flag for a
//         command that arrived while a sequence was still running.
//   cfg : cfg_wr_en/cfg_wr_data write half_period_ticks (ticks per SCK
//         half period and per CS step, 0 acts as 1). Write only while idle.
// The result of a request is in the result register on the cycle after it
// is taken. One request per cycle is sustained while results are taken; the
// next-state logic is a single pass from the state registers to the result
// register. A stalled receiver holds the result register; req.ready drops
// only while that register is full and not being taken.
// Reset (rst, synchronous) returns to idle with CS low, SCK high, SIO
// released, the tick counter cleared and half_period_ticks at 48.
`default_nettype none

module three_wire_rtc_serial_master (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data,
  twrtc_req_if.sink        req,
  twrtc_rsp_if.source      rsp
);

  // Configuration
  logic [15:0] half_period_ticks;

  // Sequencer state
  twrtc_pkg::mode_t mode, mode_next;
  logic [4:0]       half_bit, half_bit_next;
  logic [15:0]      tick_count, tick_count_next;
  logic [7:0]       shift_byte, shift_byte_next;
  twrtc_pkg::pins_t pins, pins_next;

  // Per-request result flags
  logic             done_read, reject_req;

  // Result register
  logic             rsp_valid;
  logic             take;

  logic [15:0]      limit;
  logic [16:0]      tick_inc;
  logic [4:0]       half_bit_inc;

  // Accept whenever the result register is empty or being drained
  assign req.ready = !rsp_valid || rsp.ready;
  assign take      = req.valid && req.ready;

  assign limit        = (half_period_ticks == 16'd0) ? 16'd1 : half_period_ticks;
  assign tick_inc     = {1'b0, tick_count} + 17'd1;
  assign half_bit_inc = half_bit + 5'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      half_period_ticks <= twrtc_pkg::HALF_PERIOD_RESET;
    end else if (cfg_wr_en) begin
      half_period_ticks <= cfg_wr_data;
    end
  end

  // Next state: tick handling, step advance, request start and reject
  always_comb begin
    mode_next       = mode;
    half_bit_next   = half_bit;
    tick_count_next = tick_count;
    shift_byte_next = shift_byte;
    pins_next       = pins;
    done_read       = 1'b0;
    reject_req      = 1'b0;

    if (req.action == twrtc_pkg::ACT_TICK) begin
      // Ticks only matter while a sequence runs
      if (mode != twrtc_pkg::MODE_IDLE) begin
        if (tick_inc >= {1'b0, limit}) begin
          tick_count_next = 16'd0;
          unique case (mode)
            twrtc_pkg::MODE_OPEN: begin
              // Open drops CS; first step raises it with SCK and SIO high, second starts the byte
              if (half_bit == 5'd0) begin
                half_bit_next = 5'd1;
                pins_next     = '{cs: 1'b1, sck: 1'b1, drv: 1'b1, lvl: 1'b1};
              end else begin
                mode_next     = twrtc_pkg::MODE_CMD;
                half_bit_next = 5'd0;
                pins_next     = twrtc_pkg::bit_pins(twrtc_pkg::MODE_CMD, 5'd0, shift_byte);
              end
            end
            twrtc_pkg::MODE_CLOSE: begin
              mode_next     = twrtc_pkg::MODE_IDLE;
              half_bit_next = 5'd0;
            end
            default: begin
              // Shift at the end of each SCK-high half period
              if (half_bit[0]) begin
                if (mode == twrtc_pkg::MODE_CMD) begin
                  shift_byte_next = {shift_byte[6:0], 1'b0};
                end else if (mode == twrtc_pkg::MODE_PARAM) begin
                  shift_byte_next = {1'b0, shift_byte[7:1]};
                end else begin
                  shift_byte_next = {req.sio_in, shift_byte[7:1]};
                end
              end
              if (half_bit_inc >= twrtc_pkg::HALF_BITS_PER_BYTE) begin
                done_read     = (mode == twrtc_pkg::MODE_READ);
                mode_next     = twrtc_pkg::MODE_IDLE;
                half_bit_next = 5'd0;
              end else begin
                half_bit_next = half_bit_inc;
                pins_next     = twrtc_pkg::bit_pins(mode, half_bit_inc, shift_byte_next);
              end
            end
          endcase
        end else begin
          tick_count_next = tick_inc[15:0];
        end
      end
    end else if (req.action <= twrtc_pkg::ACT_CLOSE) begin
      if (mode != twrtc_pkg::MODE_IDLE) begin
        reject_req = 1'b1;
      end else begin
        tick_count_next = 16'd0;
        half_bit_next   = 5'd0;
        unique case (req.action)
          twrtc_pkg::ACT_OPEN: begin
            mode_next       = twrtc_pkg::MODE_OPEN;
            shift_byte_next = req.data_byte;
            pins_next       = '{cs: 1'b0, sck: 1'b1, drv: 1'b1, lvl: 1'b1};
          end
          twrtc_pkg::ACT_PARAM: begin
            mode_next       = twrtc_pkg::MODE_PARAM;
            shift_byte_next = req.data_byte;
            pins_next       = twrtc_pkg::bit_pins(twrtc_pkg::MODE_PARAM, 5'd0, req.data_byte);
          end
          twrtc_pkg::ACT_READ: begin
            mode_next       = twrtc_pkg::MODE_READ;
            shift_byte_next = 8'd0;
            pins_next       = twrtc_pkg::bit_pins(twrtc_pkg::MODE_READ, 5'd0, 8'd0);
          end
          default: begin
            // Close: CS low, SCK high, SIO released for one step
            mode_next = twrtc_pkg::MODE_CLOSE;
            pins_next = twrtc_pkg::PINS_RESET;
          end
        endcase
      end
    end
  end

  // Advance state only on an accepted request
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= twrtc_pkg::MODE_IDLE;
      half_bit   <= 5'd0;
      tick_count <= 16'd0;
      shift_byte <= 8'd0;
      pins       <= twrtc_pkg::PINS_RESET;
    end else if (take) begin
      mode       <= mode_next;
      half_bit   <= half_bit_next;
      tick_count <= tick_count_next;
      shift_byte <= shift_byte_next;
      pins       <= pins_next;
    end
  end

  // Result register: load on accept, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (take) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      rsp.cs_level   <= pins_next.cs;
      rsp.sck_level  <= pins_next.sck;
      rsp.sio_drive  <= pins_next.drv;
      rsp.sio_level  <= pins_next.lvl;
      rsp.read_data  <= done_read ? shift_byte_next : 8'd0;
      rsp.read_valid <= done_read;
      rsp.busy_res   <= (mode_next != twrtc_pkg::MODE_IDLE);
      rsp.rejected   <= reject_req;
    end
  end

  assign rsp.valid = rsp_valid;

endmodule

`default_nettype wire

// ----- tb/twrtc_tb_pkg.sv -----
`timescale 1ns / 100ps
// Scoreboard for the three-wire RTC serial master testbench: an untimed model
// of the link state and the queue of results it predicts.
// Depends on twrtc_pkg.

package twrtc_tb_pkg;

  // Action codes the block does not decode
  localparam logic [2:0] ACT_UNUSED_LO = 3'd5;
  localparam logic [2:0] ACT_UNUSED_HI = 3'd7;

  typedef struct packed {
    logic       cs;
    logic       sck;
    logic       drv;
    logic       lvl;
    logic [7:0] read_data;
    logic       read_valid;
    logic       busy;
    logic       rejected;
  } link_result_t;

  class rtc_link_scoreboard;
    logic [15:0]       half_period;
    twrtc_pkg::mode_t  mode;
    logic [4:0]        half_bit;
    logic [15:0]       tick_count;
    logic [7:0]        shift;
    twrtc_pkg::pins_t  pins;
    link_result_t      pending_results[$];
    int unsigned       mismatches;

    function new();
      half_period = twrtc_pkg::HALF_PERIOD_RESET;
      mode        = twrtc_pkg::MODE_IDLE;
      half_bit    = '0;
      tick_count  = '0;
      shift       = '0;
      pins        = twrtc_pkg::PINS_RESET;
      mismatches  = 0;
    endfunction

    function void set_half_period(logic [15:0] value);
      half_period = value;
    endfunction

    function bit link_busy();
      return mode != twrtc_pkg::MODE_IDLE;
    endfunction

    function int unsigned outstanding();
      return pending_results.size();
    endfunction

    // Pins for the current half period of a data byte
    function void data_pins();
      pins.cs  = 1'b1;
      pins.sck = half_bit[0];
      pins.drv = (mode == twrtc_pkg::MODE_CMD) || (mode == twrtc_pkg::MODE_PARAM);
      if (mode == twrtc_pkg::MODE_CMD) pins.lvl = shift[7];
      else if (mode == twrtc_pkg::MODE_PARAM) pins.lvl = shift[0];
      else pins.lvl = 1'b0;
    endfunction

    // Close the current step; report a completed read byte
    function bit end_step(logic sio);
      bit done;
      done = 1'b0;
      case (mode)
        twrtc_pkg::MODE_OPEN: begin
          half_bit++;
          if (half_bit == 5'd1) begin
            pins = '{cs: 1'b1, sck: 1'b1, drv: 1'b1, lvl: 1'b1};
          end else begin
            mode     = twrtc_pkg::MODE_CMD;
            half_bit = '0;
            data_pins();
          end
        end
        twrtc_pkg::MODE_CLOSE: begin
          mode     = twrtc_pkg::MODE_IDLE;
          half_bit = '0;
        end
        default: begin
          if (half_bit[0]) begin
            if (mode == twrtc_pkg::MODE_CMD) shift = shift << 1;
            else if (mode == twrtc_pkg::MODE_PARAM) shift = shift >> 1;
            else shift = {sio, shift[7:1]};
          end
          half_bit++;
          if (half_bit >= twrtc_pkg::HALF_BITS_PER_BYTE) begin
            done     = (mode == twrtc_pkg::MODE_READ);
            mode     = twrtc_pkg::MODE_IDLE;
            half_bit = '0;
          end else begin
            data_pins();
          end
        end
      endcase
      return done;
    endfunction

    // Advance the model by one accepted request and queue its result
    function void note_request(logic [2:0] action, logic [7:0] value, logic sio);
      link_result_t r;
      logic [15:0]  limit;
      r     = '0;
      limit = (half_period == 16'd0) ? 16'd1 : half_period;
      if (action == twrtc_pkg::ACT_TICK) begin
        if (mode != twrtc_pkg::MODE_IDLE) begin
          tick_count++;
          if (tick_count >= limit) begin
            tick_count   = '0;
            r.read_valid = end_step(sio);
          end
        end
      end else if (action <= twrtc_pkg::ACT_CLOSE) begin
        if (mode != twrtc_pkg::MODE_IDLE) begin
          r.rejected = 1'b1;
        end else begin
          tick_count = '0;
          half_bit   = '0;
          case (action)
            twrtc_pkg::ACT_OPEN: begin
              mode  = twrtc_pkg::MODE_OPEN;
              shift = value;
              pins  = '{cs: 1'b0, sck: 1'b1, drv: 1'b1, lvl: 1'b1};
            end
            twrtc_pkg::ACT_PARAM: begin
              mode  = twrtc_pkg::MODE_PARAM;
              shift = value;
              data_pins();
            end
            twrtc_pkg::ACT_READ: begin
              mode  = twrtc_pkg::MODE_READ;
              shift = '0;
              data_pins();
            end
            default: begin
              mode = twrtc_pkg::MODE_CLOSE;
              pins = '{cs: 1'b0, sck: 1'b1, drv: 1'b0, lvl: 1'b0};
            end
          endcase
        end
      end
      r.cs        = pins.cs;
      r.sck       = pins.sck;
      r.drv       = pins.drv;
      r.lvl       = pins.lvl;
      r.read_data = r.read_valid ? shift : 8'h00;
      r.busy      = (mode != twrtc_pkg::MODE_IDLE);
      pending_results.push_back(r);
    endfunction

    function void compare_field(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(link_result_t seen);
      link_result_t want;
      if (pending_results.size() == 0) begin
        $error("result with no pending request: 0x%0h", seen);
        mismatches++;
        return;
      end
      want = pending_results.pop_front();
      compare_field("cs_level", 8'(want.cs), 8'(seen.cs));
      compare_field("sck_level", 8'(want.sck), 8'(seen.sck));
      compare_field("sio_drive", 8'(want.drv), 8'(seen.drv));
      compare_field("sio_level", 8'(want.lvl), 8'(seen.lvl));
      compare_field("read_data", want.read_data, seen.read_data);
      compare_field("read_valid", 8'(want.read_valid), 8'(seen.read_valid));
      compare_field("busy_res", 8'(want.busy), 8'(seen.busy));
      compare_field("rejected", 8'(want.rejected), 8'(seen.rejected));
    endfunction
  endclass

endpackage

// ----- tb/tb_three_wire_rtc_serial_master.sv -----
`timescale 1ns / 100ps
// Top of the three-wire RTC serial master testbench: clock, reset, request
// driver, result sink and the stimulus phases.
// Depends on twrtc_pkg, twrtc_tb_pkg, twrtc_req_if, twrtc_rsp_if and the RTL top.

module tb_three_wire_rtc_serial_master;

  localparam int          CLK_HALF_NS     = 10;
  localparam int          RESET_CYCLES    = 5;
  localparam int          MAX_IDLE        = 11;
  localparam int          HOLD_OFF_CYCLES = 300;
  localparam int          SETTLE_CYCLES   = 4;
  localparam int unsigned CYCLE_LIMIT     = 1_500_000;
  localparam int unsigned PHASE_REQUESTS  = 60;
  localparam int          RANDOM_PHASES   = 5;

  // Level fed on sio_in while a byte runs out
  localparam int SIO_LOW    = 0;
  localparam int SIO_HIGH   = 1;
  localparam int SIO_RANDOM = 2;

  // Back-pressure applied halfway through a random phase
  localparam int PRESS_NONE  = 0;
  localparam int PRESS_HOLD  = 1;
  localparam int PRESS_DRAIN = 2;

  logic        clk;
  logic        rst;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;

  twrtc_req_if req_ch ();
  twrtc_rsp_if rsp_ch ();

  twrtc_tb_pkg::rtc_link_scoreboard sb = new();

  bit          req_idle_on;
  bit          rsp_idle_on;
  bit          rsp_hold_request;
  int unsigned requests_sent;

  // Half periods of the random phases: small ones keep bytes short, zero must act as one
  logic [15:0] phase_half [RANDOM_PHASES] = '{16'd1, 16'd2, 16'd0, 16'd3, 16'd1};

  three_wire_rtc_serial_master u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .req        (req_ch),
    .rsp        (rsp_ch)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF_NS clk = ~clk;
  end

  // Offer one request and hold it until the block takes it. Enter and leave
  // at a falling edge; valid stays high on exit so back-to-back requests
  // never see it dropped and raised in the same step.
  task automatic push_request(input logic [2:0] action, input logic [7:0] value,
                              input logic sio);
    int unsigned gap;
    gap = req_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.action    <= action;
    req_ch.data_byte <= value;
    req_ch.sio_in    <= sio;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    sb.note_request(action, value, sio);
    if (action <= twrtc_pkg::ACT_CLOSE) requests_sent++;
    @(negedge clk);
  endtask

  // Drop valid and hold off until every result has been taken
  task automatic drain_results();
    req_ch.valid <= 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
    @(negedge clk);
  endtask

  // Write the half period once the link is idle and all results are in
  task automatic write_half_period(input logic [15:0] value);
    drain_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_half_period(value);
  endtask

  // Tick the running sequence to its end with a chosen data-line level
  task automatic finish_link(input int policy);
    logic s;
    while (sb.link_busy()) begin
      case (policy)
        SIO_LOW:  s = 1'b0;
        SIO_HIGH: s = 1'b1;
        default:  s = 1'($urandom);
      endcase
      push_request(twrtc_pkg::ACT_TICK, 8'($urandom), s);
    end
  endtask

  // Issue a request, then tick it through; now and then slip in a request
  // that must be rejected or an undecoded action that must be ignored
  task automatic run_request_with_noise(input logic [2:0] action, input logic [7:0] value);
    int unsigned pick;
    push_request(action, value, 1'($urandom));
    while (sb.link_busy()) begin
      pick = $urandom_range(0, 31);
      if (pick == 0)
        push_request(3'($urandom_range(twrtc_pkg::ACT_OPEN, twrtc_pkg::ACT_CLOSE)),
                     8'($urandom), 1'($urandom));
      else if (pick == 1)
        push_request(3'($urandom_range(twrtc_tb_pkg::ACT_UNUSED_LO,
                                       twrtc_tb_pkg::ACT_UNUSED_HI)),
                     8'($urandom), 1'($urandom));
      else
        push_request(twrtc_pkg::ACT_TICK, 8'($urandom), 1'($urandom));
    end
  endtask

  // Mostly well-formed transfers (open, a few parameter or read bytes,
  // close) with random content; sometimes drop the open or the close, and
  // sometimes tick an idle link.
  task automatic run_random_phase(input int unsigned goal, input int pressure);
    int unsigned start;
    int unsigned n_bytes;
    bit          pressure_done;
    start         = requests_sent;
    pressure_done = 1'b0;
    while (requests_sent - start < goal) begin
      if (!pressure_done && requests_sent - start >= goal / 2) begin
        pressure_done = 1'b1;
        if (pressure == PRESS_HOLD) rsp_hold_request = 1'b1;
        else if (pressure == PRESS_DRAIN) drain_results();
      end
      if ($urandom_range(0, 3) != 0)
        run_request_with_noise(twrtc_pkg::ACT_OPEN, 8'($urandom));
      n_bytes = $urandom_range(0, 3);
      repeat (n_bytes)
        run_request_with_noise($urandom_range(0, 1) ? twrtc_pkg::ACT_PARAM
                                                    : twrtc_pkg::ACT_READ, 8'($urandom));
      if ($urandom_range(0, 3) != 0)
        run_request_with_noise(twrtc_pkg::ACT_CLOSE, 8'($urandom));
      if ($urandom_range(0, 3) == 0)
        push_request(twrtc_pkg::ACT_TICK, 8'($urandom), 1'($urandom));
    end
  endtask

  // Result sink: random stalls per result, one long hold-off on demand
  initial begin : result_sink
    int unsigned                gap;
    twrtc_tb_pkg::link_result_t seen;
    rsp_ch.ready = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk);
    forever begin
      if (rsp_hold_request) begin
        gap              = HOLD_OFF_CYCLES;
        rsp_hold_request = 1'b0;
      end else begin
        gap = rsp_idle_on ? $urandom_range(0, MAX_IDLE) : 0;
      end
      if (gap != 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
      do @(posedge clk); while (rsp_ch.valid !== 1'b1);
      seen.cs         = rsp_ch.cs_level;
      seen.sck        = rsp_ch.sck_level;
      seen.drv        = rsp_ch.sio_drive;
      seen.lvl        = rsp_ch.sio_level;
      seen.read_data  = rsp_ch.read_data;
      seen.read_valid = rsp_ch.read_valid;
      seen.busy       = rsp_ch.busy_res;
      seen.rejected   = rsp_ch.rejected;
      sb.check_result(seen);
      @(negedge clk);
    end
  end

  // Cap the run length in case the handshake hangs
  initial begin : watchdog
    int unsigned cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[three_wire_rtc_serial_master] ERROR");
    $finish;
  end

  initial begin : stimulus
    rst              = 1'b1;
    cfg_wr_en        = 1'b0;
    cfg_wr_data      = '0;
    req_ch.valid     = 1'b0;
    req_ch.action    = twrtc_pkg::ACT_TICK;
    req_ch.data_byte = '0;
    req_ch.sio_in    = 1'b0;
    req_idle_on      = 1'b1;
    rsp_idle_on      = 1'b1;
    rsp_hold_request = 1'b0;
    requests_sent    = 0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    // Reset half period: idle tick and undecoded actions do nothing
    push_request(twrtc_pkg::ACT_TICK, 8'h00, 1'b0);
    push_request(twrtc_tb_pkg::ACT_UNUSED_LO, 8'hFF, 1'b1);
    push_request(twrtc_tb_pkg::ACT_UNUSED_LO + 3'd1, 8'h00, 1'b0);
    push_request(twrtc_tb_pkg::ACT_UNUSED_HI, 8'hFF, 1'b1);

    // Close step at the reset half period; every command during it must be rejected
    push_request(twrtc_pkg::ACT_CLOSE, 8'hA5, 1'b0);
    repeat (20) push_request(twrtc_pkg::ACT_TICK, 8'($urandom), 1'($urandom));
    push_request(twrtc_pkg::ACT_PARAM, 8'h3C, 1'b1);
    push_request(twrtc_pkg::ACT_READ, 8'h00, 1'b0);
    repeat (20) push_request(twrtc_pkg::ACT_TICK, 8'($urandom), 1'($urandom));
    push_request(twrtc_pkg::ACT_CLOSE, 8'hFF, 1'b1);
    push_request(twrtc_pkg::ACT_OPEN, 8'h00, 1'b0);
    push_request(twrtc_tb_pkg::ACT_UNUSED_HI, 8'h81, 1'b1);
    finish_link(SIO_RANDOM);

    // Zero half period acts as one tick; bytes without an open drive CS themselves
    write_half_period(16'd0);
    push_request(twrtc_pkg::ACT_PARAM, 8'h00, 1'b0);
    finish_link(SIO_RANDOM);
    push_request(twrtc_pkg::ACT_PARAM, 8'hFF, 1'b1);
    finish_link(SIO_RANDOM);
    push_request(twrtc_pkg::ACT_READ, 8'h00, 1'b0);
    finish_link(SIO_HIGH);
    push_request(twrtc_pkg::ACT_READ, 8'hFF, 1'b1);
    finish_link(SIO_LOW);
    push_request(twrtc_pkg::ACT_READ, 8'h5A, 1'b0);
    finish_link(SIO_RANDOM);
    push_request(twrtc_pkg::ACT_CLOSE, 8'h00, 1'b0);
    finish_link(SIO_RANDOM);
    push_request(twrtc_pkg::ACT_CLOSE, 8'h00, 1'b1);
    finish_link(SIO_RANDOM);
    push_request(twrtc_pkg::ACT_OPEN, 8'hFF, 1'b1);
    finish_link(SIO_RANDOM);
    push_request(twrtc_pkg::ACT_OPEN, 8'h00, 1'b0);
    finish_link(SIO_RANDOM);
    push_request(twrtc_pkg::ACT_TICK, 8'hFF, 1'b1);

    // Random transfers; vary idling per phase so both sides see stretches
    // with and without gaps. Phase 1 holds off the sink long enough to
    // back up the block; phase 3 lets every result drain mid-phase.
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      req_idle_on = (p != 1) && (p != 2);
      rsp_idle_on = (p != 2) && (p != 3);
      write_half_period(phase_half[p]);
      run_random_phase(PHASE_REQUESTS,
                       (p == 1) ? PRESS_HOLD : ((p == 3) ? PRESS_DRAIN : PRESS_NONE));
    end

    // Longer half period: run a close step and an open with its command byte
    // through with no idling on either side
    req_idle_on = 1'b0;
    rsp_idle_on = 1'b0;
    write_half_period(16'd5);
    push_request(twrtc_pkg::ACT_CLOSE, 8'($urandom), 1'($urandom));
    finish_link(SIO_RANDOM);
    push_request(twrtc_pkg::ACT_OPEN, 8'($urandom), 1'($urandom));
    finish_link(SIO_RANDOM);

    // Wait out the remaining results, then settle
    drain_results();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0) begin
      $display("[three_wire_rtc_serial_master] OK");
    end else begin
      $display("[three_wire_rtc_serial_master] ERROR");
    end
    $finish;
  end

endmodule
